/* rtl/edpp_pkg.sv */
// shared widths, configuration types and helpers of the edge projection unit
package edpp_pkg;

   localparam int COORD_BITS = 16;

   // configuration register widths
   localparam int FOCUS_W  = 16;
   localparam int DOFS_W   = 18;
   localparam int LOFS_W   = 17;
   localparam int CENTER_W = 16;
   localparam int CSR_W    = 18;
   localparam int CSR_IDX_W = 3;

   // arithmetic widths
   localparam int SUM_W   = ((COORD_BITS > LOFS_W) ? COORD_BITS : LOFS_W) + 1;
   localparam int PROD_W  = SUM_W + FOCUS_W;
   localparam int MAG_W   = PROD_W - 1;
   localparam int DEPTH_W = ((COORD_BITS > DOFS_W) ? COORD_BITS : DOFS_W) + 1;
   localparam int DIV_W   = DEPTH_W - 1;
   localparam int Q_W     = MAG_W + 1;
   localparam int RES_W   = ((Q_W > CENTER_W) ? Q_W : CENTER_W) + 1;

   // lane pipeline depth: front, multiply, magnitude, divider, sign, output
   localparam int LANE_LAT = MAG_W + 5;

   // stream widths
   localparam int IN_W  = ((6 * COORD_BITS + 7) / 8) * 8;
   localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCUS    = 3'd0,
      CSR_DEPTH    = 3'd1,
      CSR_X_OFS    = 3'd2,
      CSR_Z_OFS    = 3'd3,
      CSR_CENTER_X = 3'd4,
      CSR_CENTER_Y = 3'd5
   } csr_idx_type;

   localparam logic [FOCUS_W-1:0] FOCUS_RST = FOCUS_W'(256);
   localparam logic [DOFS_W-1:0]  DOFS_RST  = DOFS_W'(256);

   typedef struct packed {
      logic [FOCUS_W-1:0]  focus;
      logic [DOFS_W-1:0]   depth_offset;
      logic [LOFS_W-1:0]   x_offset;
      logic [LOFS_W-1:0]   z_offset;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
   } cfg_type;

   localparam logic signed [RES_W-1:0] SAT_HI =
      {{(RES_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [RES_W-1:0] v);
      logic signed [RES_W-1:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return r[COORD_BITS-1:0];
   endfunction

endpackage

/* rtl/edge_perspective_projection_unit.sv */
// edge perspective projection unit: top level with config registers and merge stage
// throughput: one edge per cycle while no result is held; the 33-stage divider in each lane is fully pipelined
// the whole pipeline holds while a result waits on rsp_tready, so no item is dropped
// reset (synchronous, active high) empties the pipeline and loads register defaults
// focus 256, depth offset 256, all other registers zero
module edge_perspective_projection_unit (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write port
   input  logic                             csr_wr_en,
   input  logic [edpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [edpp_pkg::CSR_W-1:0]       csr_wdata,
   // edge items in
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [edpp_pkg::IN_W-1:0]        req_tdata,  // ax, ay_depth, az, bx, by_depth, bz
   // projected items out
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [edpp_pkg::OUT_W-1:0]       rsp_tdata,  // screen_ax, screen_ay, screen_bx, screen_by
   output logic [1:0]                       rsp_tuser   // depth_fault
);
   localparam int C = edpp_pkg::COORD_BITS;
   localparam int L = edpp_pkg::LANE_LAT;

   edpp_pkg::cfg_type cfg_ff;

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focus        <= edpp_pkg::FOCUS_RST;
         cfg_ff.depth_offset <= edpp_pkg::DOFS_RST;
         cfg_ff.x_offset     <= '0;
         cfg_ff.z_offset     <= '0;
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
      end else if (csr_wr_en) begin
         case (edpp_pkg::csr_idx_type'(csr_index))
            edpp_pkg::CSR_FOCUS:    cfg_ff.focus        <= csr_wdata[edpp_pkg::FOCUS_W-1:0];
            edpp_pkg::CSR_DEPTH:    cfg_ff.depth_offset <= csr_wdata[edpp_pkg::DOFS_W-1:0];
            edpp_pkg::CSR_X_OFS:    cfg_ff.x_offset     <= csr_wdata[edpp_pkg::LOFS_W-1:0];
            edpp_pkg::CSR_Z_OFS:    cfg_ff.z_offset     <= csr_wdata[edpp_pkg::LOFS_W-1:0];
            edpp_pkg::CSR_CENTER_X: cfg_ff.center_x     <= csr_wdata[edpp_pkg::CENTER_W-1:0];
            edpp_pkg::CSR_CENTER_Y: cfg_ff.center_y     <= csr_wdata[edpp_pkg::CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: move whenever the output slot is free or being taken
   logic         adv;
   logic [L-1:0] vld_ff;
   logic [L-1:0] vld_in;

   assign adv        = ~vld_ff[L-1] | rsp_tready;
   assign req_tready = adv;
   assign vld_in     = {vld_ff[L-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // one lane per endpoint
   logic signed [C-1:0] sax, say, sbx, sby;
   logic                fa, fb;

   edpp_lane u_lane_a (
      .clock(clock), .adv(adv), .cfg(cfg_ff),
      .x($signed(req_tdata[0*C +: C])),
      .y($signed(req_tdata[1*C +: C])),
      .z($signed(req_tdata[2*C +: C])),
      .sx(sax), .sy(say), .fault(fa)
   );

   edpp_lane u_lane_b (
      .clock(clock), .adv(adv), .cfg(cfg_ff),
      .x($signed(req_tdata[3*C +: C])),
      .y($signed(req_tdata[4*C +: C])),
      .z($signed(req_tdata[5*C +: C])),
      .sx(sbx), .sy(sby), .fault(fb)
   );

   // merge: pack both endpoints and collect the depth flags
   assign rsp_tvalid = vld_ff[L-1];
   assign rsp_tdata  = edpp_pkg::OUT_W'({sby, sbx, say, sax});
   assign rsp_tuser  = {fb, fa};

   // a taken result always frees room for the next item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> req_tready)
      else $error("pipeline held while result taken");

   // reset empties the pipeline and restores the focus default
   assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && cfg_ff.focus == edpp_pkg::FOCUS_RST))
      else $error("reset state wrong");

   // a focus write lands in the register
   assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && csr_index == edpp_pkg::CSR_FOCUS)
      |=> cfg_ff.focus == $past(csr_wdata[edpp_pkg::FOCUS_W-1:0]))
      else $error("focus write lost");
endmodule

/* rtl/edpp_div.sv */
// pipelined restoring divider, one quotient bit per stage
module edpp_div (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [edpp_pkg::MAG_W-1:0]  num,
   input  logic [edpp_pkg::DIV_W-1:0]  dvs,
   input  logic                        neg,
   output logic [edpp_pkg::MAG_W-1:0]  quo,
   output logic                        neg_out
);
   localparam int MW = edpp_pkg::MAG_W;
   localparam int DW = edpp_pkg::DIV_W;

   logic [DW-1:0] rem_ff [MW];
   logic [MW-1:0] num_ff [MW];
   logic [DW-1:0] dvs_ff [MW];
   logic          neg_ff [MW];

   for (genvar k = 0; k < MW; k++) begin : g_stage
      logic [DW-1:0] rem_p;
      logic [DW-1:0] dvs_p;
      logic [MW-1:0] num_p;
      logic          neg_p;
      logic [DW:0]   trial;
      logic [DW:0]   diff;

      if (k == 0) begin : g_first
         assign rem_p = '0;
         assign num_p = num;
         assign dvs_p = dvs;
         assign neg_p = neg;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign num_p = num_ff[k-1];
         assign dvs_p = dvs_ff[k-1];
         assign neg_p = neg_ff[k-1];
      end

      assign trial = {rem_p, num_p[MW-1]};
      assign diff  = trial - {1'b0, dvs_p};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            num_ff[k] <= {num_p[MW-2:0], ~diff[DW]};
            dvs_ff[k] <= dvs_p;
            neg_ff[k] <= neg_p;
         end
      end
   end

   assign quo     = num_ff[MW-1];
   assign neg_out = neg_ff[MW-1];
endmodule

/* rtl/edpp_lane.sv */
// projection lane for one endpoint: offsets, depth clamp, scale, divide, saturate
module edpp_lane (
   input  logic                                  clock,
   input  logic                                  adv,
   input  edpp_pkg::cfg_type                     cfg,
   input  logic signed [edpp_pkg::COORD_BITS-1:0] x,
   input  logic signed [edpp_pkg::COORD_BITS-1:0] y,
   input  logic signed [edpp_pkg::COORD_BITS-1:0] z,
   output logic signed [edpp_pkg::COORD_BITS-1:0] sx,
   output logic signed [edpp_pkg::COORD_BITS-1:0] sy,
   output logic                                  fault
);
   localparam int SW = edpp_pkg::SUM_W;
   localparam int PW = edpp_pkg::PROD_W;
   localparam int MW = edpp_pkg::MAG_W;
   localparam int DEW = edpp_pkg::DEPTH_W;
   localparam int DW = edpp_pkg::DIV_W;
   localparam int QW = edpp_pkg::Q_W;
   localparam int RW = edpp_pkg::RES_W;
   localparam int FD = edpp_pkg::LANE_LAT;

   // front stage
   logic signed [SW-1:0]  sum_x_ff, sum_z_ff;
   logic signed [DEW-1:0] depth;
   logic [DW-1:0]         dvs_ff;
   logic [FD-1:0]         flt_ff;

   assign depth = DEW'($signed(cfg.depth_offset)) + DEW'(y);

   // multiply stage
   logic signed [PW-1:0] prod_x_ff, prod_z_ff;
   logic [DW-1:0]        dvs2_ff;
   logic signed [PW-1:0] focus_s;

   assign focus_s = PW'($signed({1'b0, cfg.focus}));

   // magnitude stage
   logic [MW-1:0] mag_x_ff, mag_z_ff;
   logic          neg_x_ff, neg_z_ff;
   logic [DW-1:0] dvs3_ff;
   logic signed [PW-1:0] abs_x, abs_z;

   assign abs_x = prod_x_ff[PW-1] ? -prod_x_ff : prod_x_ff;
   assign abs_z = prod_z_ff[PW-1] ? -prod_z_ff : prod_z_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_x_ff  <= SW'(x) + SW'($signed(cfg.x_offset));
         sum_z_ff  <= SW'(z) + SW'($signed(cfg.z_offset));
         dvs_ff    <= (depth <= 0) ? DW'(1) : depth[DW-1:0];
         flt_ff    <= {flt_ff[FD-2:0], (depth <= 0)};
         prod_x_ff <= PW'(sum_x_ff) * focus_s;
         prod_z_ff <= PW'(sum_z_ff) * focus_s;
         dvs2_ff   <= dvs_ff;
         mag_x_ff  <= abs_x[MW-1:0];
         mag_z_ff  <= abs_z[MW-1:0];
         neg_x_ff  <= prod_x_ff[PW-1];
         neg_z_ff  <= prod_z_ff[PW-1];
         dvs3_ff   <= dvs2_ff;
      end
   end

   logic [MW-1:0] quo_x, quo_z;
   logic          qneg_x, qneg_z;

   edpp_div u_div_x (
      .clock(clock), .adv(adv), .num(mag_x_ff), .dvs(dvs3_ff), .neg(neg_x_ff),
      .quo(quo_x), .neg_out(qneg_x)
   );

   edpp_div u_div_z (
      .clock(clock), .adv(adv), .num(mag_z_ff), .dvs(dvs3_ff), .neg(neg_z_ff),
      .quo(quo_z), .neg_out(qneg_z)
   );

   // sign restore, then center add and saturation
   logic signed [QW-1:0] q_x_ff, q_z_ff;
   logic signed [QW-1:0] qp_x, qp_z;
   logic signed [edpp_pkg::COORD_BITS-1:0] sx_ff, sy_ff;

   assign qp_x = $signed({1'b0, quo_x});
   assign qp_z = $signed({1'b0, quo_z});

   always_ff @(posedge clock) begin
      if (adv) begin
         q_x_ff <= qneg_x ? -qp_x : qp_x;
         q_z_ff <= qneg_z ? -qp_z : qp_z;
         sx_ff  <= edpp_pkg::sat_coord(RW'(q_x_ff) + RW'($signed(cfg.center_x)));
         sy_ff  <= edpp_pkg::sat_coord(RW'(q_z_ff) + RW'($signed(cfg.center_y)));
      end
   end

   assign sx    = sx_ff;
   assign sy    = sy_ff;
   assign fault = flt_ff[FD-1];
endmodule

/* verif/tb_top.sv */
// self-checking testbench of the edge perspective projection unit
module tb_top;

   // one projected edge as it leaves the block
   typedef struct packed {
      logic [edpp_pkg::COORD_BITS-1:0] screen_ax;
      logic [edpp_pkg::COORD_BITS-1:0] screen_ay;
      logic [edpp_pkg::COORD_BITS-1:0] screen_bx;
      logic [edpp_pkg::COORD_BITS-1:0] screen_by;
      logic [1:0]                      depth_fault;
   } edge_proj_type;

   // a directed stimulus row, with a hand-worked answer where one is obvious
   typedef struct {
      logic [edpp_pkg::IN_W-1:0] edge_data;
      bit                        hand_worked;
      edge_proj_type             hand_result;
   } edge_row_type;

   // index with no register behind it, written to show the block ignores it
   localparam logic [edpp_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd6;
   localparam int DRAIN_WAIT  = edpp_pkg::LANE_LAT + 10;   // pipeline depth plus margin
   localparam int STALL_LIMIT = 20000;                     // cycles with no item moving
   localparam int RAND_ITEMS  = 800;
   localparam int PHASES      = 8;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [edpp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [edpp_pkg::CSR_W-1:0]     csr_wdata;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [edpp_pkg::IN_W-1:0]      req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [edpp_pkg::OUT_W-1:0]     rsp_tdata;
   logic [1:0]                     rsp_tuser;

   // travel with req_tdata so the hand-worked answer lines up with its item
   logic                 req_hand_worked;
   edge_proj_type        req_hand_result;

   // shadow copy of the configuration registers
   logic [edpp_pkg::FOCUS_W-1:0]         sh_focus;
   logic signed [edpp_pkg::DOFS_W-1:0]   sh_depth;
   logic signed [edpp_pkg::LOFS_W-1:0]   sh_x_ofs;
   logic signed [edpp_pkg::LOFS_W-1:0]   sh_z_ofs;
   logic signed [edpp_pkg::CENTER_W-1:0] sh_center_x;
   logic signed [edpp_pkg::CENTER_W-1:0] sh_center_y;

   edge_proj_type pending_proj[$];   // projections still due from the block
   edge_row_type  directed_rows[$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned mismatches;
   int unsigned edges_in;
   int unsigned edges_out;
   int unsigned clamped_points;
   int unsigned stall_cycles;

   edge_perspective_projection_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // ax, ay_depth, az, bx, by_depth, bz
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // screen_ax, screen_ay, screen_bx, screen_by
      .rsp_tuser  (rsp_tuser)    // depth_fault
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // clamp a wide sum into the signed screen range
   function automatic logic [edpp_pkg::COORD_BITS-1:0] clip_screen(input longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[edpp_pkg::COORD_BITS-1:0];
   endfunction

   // pinhole projection of one endpoint; returns 1 when depth had to be clamped
   function automatic bit project_point(input logic signed [edpp_pkg::COORD_BITS-1:0] x,
         input logic signed [edpp_pkg::COORD_BITS-1:0] y,
         input logic signed [edpp_pkg::COORD_BITS-1:0] z,
         output logic [edpp_pkg::COORD_BITS-1:0] sx,
         output logic [edpp_pkg::COORD_BITS-1:0] sy);
      longint depth;
      longint num_x;
      longint num_z;
      bit     clamped;
      depth   = longint'(sh_depth) + longint'(y);
      clamped = (depth <= 0);
      if (clamped) depth = 1;
      num_x = (longint'(x) + longint'(sh_x_ofs)) * longint'(sh_focus);
      num_z = (longint'(z) + longint'(sh_z_ofs)) * longint'(sh_focus);
      // longint division truncates toward zero, as the block must
      sx = clip_screen(longint'(sh_center_x) + num_x / depth);
      sy = clip_screen(longint'(sh_center_y) + num_z / depth);
      return clamped;
   endfunction

   function automatic edge_proj_type project_edge(input logic [edpp_pkg::IN_W-1:0] d);
      edge_proj_type p;
      p.depth_fault[0] = project_point(d[15:0], d[31:16], d[47:32],
                                       p.screen_ax, p.screen_ay);
      p.depth_fault[1] = project_point(d[63:48], d[79:64], d[95:80],
                                       p.screen_bx, p.screen_by);
      return p;
   endfunction

   function automatic logic [edpp_pkg::IN_W-1:0] pack_edge(input int ax, input int ay,
         input int az, input int bx, input int by, input int bz);
      logic [edpp_pkg::COORD_BITS-1:0] f [6];
      f = '{ax[15:0], ay[15:0], az[15:0], bx[15:0], by[15:0], bz[15:0]};
      return {f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   function automatic edge_proj_type proj(input int sax, input int say, input int sbx,
         input int sby, input int fault);
      return '{sax[15:0], say[15:0], sbx[15:0], sby[15:0], fault[1:0]};
   endfunction

   // random coordinate: mostly uniform, sometimes an edge value or near the clamp point
   function automatic int pick_coord(input bit is_depth);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 4))
            0: return -32768;
            1: return -1;
            2: return 0;
            3: return 1;
            default: return 32767;
         endcase
      end
      if (is_depth && r == 1) return -int'(sh_depth) + $urandom_range(0, 6) - 3;
      return $urandom_range(0, 65535) - 32768;
   endfunction

   // scoreboard side: predict on every accepted edge, check on every result
   always @(posedge clock) begin
      edge_proj_type got;
      edge_proj_type want;
      if (!reset && req_tvalid && req_tready) begin
         want = req_hand_worked ? req_hand_result : project_edge(req_tdata);
         pending_proj.push_back(want);
         edges_in <= edges_in + 1;
         clamped_points <= clamped_points + want.depth_fault[0] + want.depth_fault[1];
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         // rsp_tdata carries screen_ax in its lowest bits
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tdata[63:48],
                rsp_tuser};
         edges_out <= edges_out + 1;
         if (pending_proj.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected projected item %h", got);
         end else begin
            want = pending_proj.pop_front();
            if (got.screen_ax !== want.screen_ax || got.screen_ay !== want.screen_ay ||
                got.screen_bx !== want.screen_bx || got.screen_by !== want.screen_by ||
                got.depth_fault !== want.depth_fault) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("item %0d: want %0d %0d %0d %0d/%b got %0d %0d %0d %0d/%b",
                     edges_out, $signed(want.screen_ax), $signed(want.screen_ay),
                     $signed(want.screen_bx), $signed(want.screen_by), want.depth_fault,
                     $signed(got.screen_ax), $signed(got.screen_ay),
                     $signed(got.screen_bx), $signed(got.screen_by), got.depth_fault);
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog: ends the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d items outstanding", pending_proj.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // offer one edge, with random gaps, until it is taken
   task automatic send_edge(input logic [edpp_pkg::IN_W-1:0] d, input bit hand,
         input edge_proj_type hr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid      <= 1'b1;
      req_tdata       <= d;
      req_hand_worked <= hand;
      req_hand_result <= hr;
      do @(posedge clock); while (!req_tready);
   endtask

   // let the pipeline empty before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_proj.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // write every register on back-to-back cycles, plus one unmapped index
   task automatic load_config(input int focus, input int depth, input int xo, input int zo,
         input int cx, input int cy);
      int vals [7];
      logic [edpp_pkg::CSR_IDX_W-1:0] idx [7];
      vals = '{focus, depth, xo, zo, cx, cy, int'($urandom_range(0, 262143))};
      idx  = '{edpp_pkg::CSR_FOCUS, edpp_pkg::CSR_DEPTH, edpp_pkg::CSR_X_OFS,
               edpp_pkg::CSR_Z_OFS, edpp_pkg::CSR_CENTER_X, edpp_pkg::CSR_CENTER_Y,
               CSR_UNMAPPED};
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i][edpp_pkg::CSR_W-1:0];
         @(posedge clock);
      end
      csr_wr_en   <= 1'b0;
      sh_focus    = focus[edpp_pkg::FOCUS_W-1:0];
      sh_depth    = depth[edpp_pkg::DOFS_W-1:0];
      sh_x_ofs    = xo[edpp_pkg::LOFS_W-1:0];
      sh_z_ofs    = zo[edpp_pkg::LOFS_W-1:0];
      sh_center_x = cx[edpp_pkg::CENTER_W-1:0];
      sh_center_y = cy[edpp_pkg::CENTER_W-1:0];
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = edpp_pkg::CSR_FOCUS;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_hand_worked = 1'b0;
      req_hand_result = '0;
      rsp_tready = 1'b0;
      send_idle_pct = 9;
      recv_idle_pct = 53;
      mismatches = 0;
      edges_in = 0;
      edges_out = 0;
      clamped_points = 0;
      stall_cycles = 0;
      // register defaults after reset
      sh_focus = 256; sh_depth = 256; sh_x_ofs = 0; sh_z_ofs = 0;
      sh_center_x = 0; sh_center_y = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed edges at reset defaults (focus 256, depth offset 256)
      directed_rows.push_back('{pack_edge(0, 0, 0, 0, 0, 0), 1, proj(0, 0, 0, 0, 0)});
      // extremes of x and z land exactly on the screen limits
      directed_rows.push_back('{pack_edge(32767, 0, -32768, -32768, 0, 32767), 1,
                                proj(32767, -32768, -32768, 32767, 0)});
      // depth of zero and far negative depth both clamp to one
      directed_rows.push_back('{pack_edge(1, -256, -1, 5, -32768, 0), 1,
                                proj(256, -256, 1280, 0, 3)});
      // depth of one: lateral result saturates
      directed_rows.push_back('{pack_edge(200, -255, 0, 0, 0, 0), 1,
                                proj(32767, 0, 0, 0, 0)});
      // negative quotients truncate toward zero
      directed_rows.push_back('{pack_edge(-3, 256, 3, -1, 0, 1), 1,
                                proj(-1, 1, -1, 1, 0)});
      directed_rows.push_back('{pack_edge(32767, 32767, -32768, -32768, 32767, 32767), 0,
                                '0});
      directed_rows.push_back('{pack_edge(-1, -1, -1, -1, -1, -1), 0, '0});
      directed_rows.push_back('{pack_edge(21845, -257, -21846, 12, -32767, -12), 0, '0});
      for (int i = 0; i < 6; i++)
         directed_rows.push_back('{pack_edge(pick_coord(0), pick_coord(1), pick_coord(0),
                                   pick_coord(0), pick_coord(1), pick_coord(0)), 0, '0});
      foreach (directed_rows[i])
         send_edge(directed_rows[i].edge_data, directed_rows[i].hand_worked,
                   directed_rows[i].hand_result);

      // random phases, each under its own register setting
      sent = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: load_config(65535, 1, 65535, -65536, 32767, -32768);     // saturation
            1: load_config(0, 131071, -65536, 65535, -32768, 32767);    // zero focus
            2: load_config(1, -131072, 1, -1, 0, 0);                    // every depth clamps
            3: load_config(256, 40000, 0, 0, 320, 240);
            default: load_config($urandom_range(0, 65535), $urandom_range(0, 262143) - 131072,
                        $urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
                        $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
         endcase
         for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
            // idling mix shifts with progress through the random part
            if (sent < RAND_ITEMS / 3) begin
               send_idle_pct = 9;  recv_idle_pct = 53;
            end else if (sent < 2 * RAND_ITEMS / 3) begin
               send_idle_pct = 53; recv_idle_pct = 9;
            end else begin
               send_idle_pct = 0;  recv_idle_pct = 0;
            end
            send_edge(pack_edge(pick_coord(0), pick_coord(1), pick_coord(0),
                                pick_coord(0), pick_coord(1), pick_coord(0)), 0, '0);
            sent++;
         end
      end

      drain();
      $display("%0d edges projected and %0d returned across %0d register settings",
               edges_in, edges_out, PHASES + 1);
      $display("%0d endpoints hit the depth clamp, %0d mismatches", clamped_points, mismatches);
      if (mismatches == 0 && pending_proj.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
rtl/edpp_pkg.sv
rtl/edpp_div.sv
rtl/edpp_lane.sv
rtl/edge_perspective_projection_unit.sv
verif/tb_top.sv
